// ===== src/dpss_pkg.sv =====
// Shared types and constants for the packet slot scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none
package dpss_pkg;

    localparam int ADDR_W = 14;
    localparam int TAG_W  = 4;
    localparam int KEY_W  = ADDR_W + TAG_W;

    localparam logic [15:0] AGE_MAX   = 16'hFFFF;
    localparam logic [7:0]  SPACER_LO = 8'h70;
    localparam logic [7:0]  SPACER_HI = 8'h7F;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_CYCLE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        SRC_NONE     = 3'd0,
        SRC_IDLE     = 3'd1,
        SRC_SPACER   = 3'd2,
        SRC_ONE_SHOT = 3'd3,
        SRC_REFRESH  = 3'd4
    } source_t;

    typedef enum logic [1:0] {
        CFG_PROMPT_BURST = 2'd0,
        CFG_COLD_DUE     = 2'd1,
        CFG_COLD_OVERDUE = 2'd2
    } cfg_index_t;

    // Tier membership of one slot, as seen during the scan.
    typedef struct packed {
        logic one_shot;
        logic any;
        logic overdue;
        logic burst;
        logic due;
    } tier_flags_t;

    // Which tiers hold a candidate once the scan has finished.
    typedef struct packed {
        logic one_shot;
        logic any;
        logic overdue;
        logic burst;
        logic due;
    } pick_found_t;

endpackage
`default_nettype wire

// ===== src/dcc_packet_slot_scheduler_top.sv =====
// Packet slot scheduler: slot table in one synchronous memory, scan sequencer, result register.
// Depends on dpss_pkg and dpss_pick.
//
// Usage: commands arrive on the input channel (in_valid/in_stall) and each one
// yields exactly one result on the output channel (out_valid/out_stall).
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// The slot fields live in a memory with one read and one write port; slot
// valid flags are flip-flops. Insert, remove and packet cycle walk the memory
// one slot per cycle; a clear or a refused one-shot skips the walk. One command
// is worked on at a time: a new command is taken only once the last result has
// been loaded into the output register.
// At reset the table is empty, cursors are zero and registers take their
// defaults (burst 4, due 16, overdue 64). A result waits in the output
// register while the receiver stalls; the next command may be taken meanwhile
// and is held finished until the output register frees up.
`default_nettype none
module dcc_packet_slot_scheduler_top
    import dpss_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int MAX_BYTES = 6
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [13:0] loco_address,
    input  wire logic [3:0]  sub_key,
    input  wire logic [2:0]  urgency,
    input  wire logic        keep_refreshing,
    input  wire logic [47:0] packet_bytes,
    input  wire logic [2:0]  packet_length,
    input  wire logic [7:0]  preamble_length,
    input  wire logic [7:0]  repeats,
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      logic        accepted,
    output      logic [2:0]  source,
    output      logic [3:0]  chosen_slot,
    output      logic [47:0] out_bytes,
    output      logic [2:0]  out_length,
    output      logic [7:0]  out_preamble,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int PKT_W = MAX_BYTES * 8;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [2:0]       rank;
        logic             refresh;
        logic [PKT_W-1:0] packet;
        logic [2:0]       length;
        logic [7:0]       preamble;
        logic [7:0]       repeats;
        logic [7:0]       burst;
        logic [15:0]      age;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_COMMIT,
        S_INSERT,
        S_EMIT
    } state_t;

    // Memory and its ports.
    entry_t           mem [SLOTS];
    entry_t           rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    entry_t           mem_wd;
    logic [IDX_W-1:0] mem_ra;

    state_t           state_reg;
    logic [SLOTS-1:0] valid_reg;
    logic [IDX_W-1:0] ring_cursor_reg;
    logic [IDX_W-1:0] cold_cursor_reg;
    logic             last_overdue_reg;
    logic [7:0]       last_first_reg;
    logic [7:0]       burst_cfg_reg;
    logic [15:0]      due_cfg_reg;
    logic [15:0]      overdue_cfg_reg;

    logic [CNT_W-1:0] cnt_reg;
    logic             rd_v_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    cmd_t             cmd_reg;
    logic [13:0]      addr_reg;
    logic [3:0]       tag_reg;
    logic [2:0]       rank_reg;
    logic             refresh_reg;
    logic [47:0]      bytes_reg;
    logic [2:0]       length_reg;
    logic [7:0]       preamble_reg;
    logic [7:0]       repeats_reg;

    logic             match_found_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic [15:0]      match_age_reg;
    logic             match_refresh_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    logic             sel_one_shot_reg;
    logic [IDX_W-1:0] sel_idx_reg;

    logic             res_accepted_reg;
    source_t          res_source_reg;
    logic [3:0]       res_slot_reg;
    logic [47:0]      res_bytes_reg;
    logic [2:0]       res_length_reg;
    logic [7:0]       res_preamble_reg;

    logic             out_valid_reg;
    logic             out_accepted_reg;
    source_t          out_source_reg;
    logic [3:0]       out_slot_reg;
    logic [47:0]      out_bytes_reg;
    logic [2:0]       out_length_reg;
    logic [7:0]       out_preamble_reg;

    // Scan datapath.
    logic             proc;
    logic             slot_live;
    logic             slot_rf;
    logic [15:0]      age_next;
    entry_t           e_aged;
    tier_flags_t      flags;
    logic             scan_done;
    logic             in_accept;

    pick_found_t      found;
    logic [IDX_W-1:0] os_idx;
    logic [IDX_W-1:0] any_idx;
    logic [IDX_W-1:0] overdue_idx;
    logic [IDX_W-1:0] burst_idx;
    logic [IDX_W-1:0] due_idx;

    // Selection after the scan.
    logic             pick_valid;
    logic             pick_one_shot;
    logic [IDX_W-1:0] pick_idx;
    logic [IDX_W-1:0] ring_next;
    logic [IDX_W-1:0] cold_next;
    logic             last_overdue_next;

    // Commit and insert.
    entry_t           e_commit;
    logic [7:0]       head_byte;
    logic             spacer;
    entry_t           e_ins;
    logic [PKT_W-1:0] kept_bytes;
    logic [47:0]      emit_bytes;

    function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] r;
        if (idx == IDX_W'(SLOTS - 1))
        begin
            r = '0;
        end
        else
        begin
            r = idx + 1'b1;
        end
        return r;
    endfunction

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    assign proc      = (state_reg == S_SCAN) && rd_v_reg;
    assign slot_live = valid_reg[rd_idx_reg];
    assign slot_rf   = slot_live && rd_data_reg.refresh;
    assign scan_done = (state_reg == S_SCAN) && !rd_v_reg && (cnt_reg == CNT_W'(SLOTS));

    always_comb
    begin
        age_next = rd_data_reg.age;
        if (due_cfg_reg != '0 && slot_rf && rd_data_reg.age != AGE_MAX)
        begin
            age_next = rd_data_reg.age + 16'd1;
        end
        e_aged     = rd_data_reg;
        e_aged.age = age_next;
        flags.any      = slot_rf;
        flags.overdue  = slot_rf && (age_next >= overdue_cfg_reg);
        flags.burst    = slot_rf && (rd_data_reg.burst != '0);
        flags.due      = slot_rf && (rd_data_reg.burst == '0) && (age_next >= due_cfg_reg);
        flags.one_shot = slot_live && !rd_data_reg.refresh && (rd_data_reg.repeats != '0);
    end

    dpss_pick #(
        .SLOTS (SLOTS)
    ) u_pick (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (in_accept),
        .step         (proc && cmd_reg == CMD_CYCLE),
        .step_idx     (rd_idx_reg),
        .flags        (flags),
        .rank         (rd_data_reg.rank),
        .ring_cursor  (ring_cursor_reg),
        .cold_cursor  (cold_cursor_reg),
        .found        (found),
        .one_shot_idx (os_idx),
        .any_idx      (any_idx),
        .overdue_idx  (overdue_idx),
        .burst_idx    (burst_idx),
        .due_idx      (due_idx)
    );

    // One-shot first. Refresh: any if due is 0, else burst after overdue, overdue, burst, due.
    always_comb
    begin
        pick_valid        = 1'b0;
        pick_one_shot     = 1'b0;
        pick_idx          = os_idx;
        ring_next         = ring_cursor_reg;
        cold_next         = cold_cursor_reg;
        last_overdue_next = last_overdue_reg;
        if (found.one_shot)
        begin
            pick_valid    = 1'b1;
            pick_one_shot = 1'b1;
        end
        else if (due_cfg_reg == '0)
        begin
            if (found.any)
            begin
                pick_valid = 1'b1;
                pick_idx   = any_idx;
                ring_next  = wrap_next(any_idx);
            end
        end
        else if (last_overdue_reg && found.burst)
        begin
            pick_valid        = 1'b1;
            pick_idx          = burst_idx;
            ring_next         = wrap_next(burst_idx);
            last_overdue_next = 1'b0;
        end
        else
        begin
            last_overdue_next = found.overdue;
            if (found.overdue)
            begin
                pick_valid = 1'b1;
                pick_idx   = overdue_idx;
                cold_next  = wrap_next(overdue_idx);
            end
            else if (found.burst)
            begin
                pick_valid = 1'b1;
                pick_idx   = burst_idx;
                ring_next  = wrap_next(burst_idx);
            end
            else if (found.due)
            begin
                pick_valid = 1'b1;
                pick_idx   = due_idx;
                cold_next  = wrap_next(due_idx);
            end
        end
    end

    always_comb
    begin
        head_byte  = rd_data_reg.packet[7:0];
        spacer     = (head_byte >= SPACER_LO) && (head_byte <= SPACER_HI)
                     && (head_byte == last_first_reg);
        e_commit   = rd_data_reg;
        if (sel_one_shot_reg)
        begin
            e_commit.repeats = rd_data_reg.repeats - 8'd1;
        end
        else
        begin
            if (rd_data_reg.burst != '0)
            begin
                e_commit.burst = rd_data_reg.burst - 8'd1;
            end
            e_commit.age = '0;
        end
        emit_bytes = 48'(rd_data_reg.packet);
    end

    // Bytes past the given length are stored as zero.
    always_comb
    begin
        kept_bytes = PKT_W'(bytes_reg);
        for (int b = 0; b < MAX_BYTES; b++)
        begin
            if (b >= int'(length_reg))
            begin
                kept_bytes[b*8 +: 8] = 8'h00;
            end
        end
        e_ins.key      = {addr_reg, tag_reg};
        e_ins.rank     = rank_reg;
        e_ins.refresh  = refresh_reg;
        e_ins.packet   = kept_bytes;
        e_ins.length   = length_reg;
        e_ins.preamble = preamble_reg;
        e_ins.repeats  = repeats_reg;
        e_ins.burst    = burst_cfg_reg;
        e_ins.age      = match_found_reg ? match_age_reg : 16'd0;
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = rd_idx_reg;
        mem_wd = e_aged;
        mem_ra = cnt_reg[IDX_W-1:0];
        case (state_reg)
            S_SCAN:
            begin
                mem_we = proc && (cmd_reg == CMD_CYCLE) && slot_rf;
            end
            S_PICK:
            begin
                mem_ra = pick_idx;
            end
            S_COMMIT:
            begin
                mem_we = !spacer;
                mem_wa = sel_idx_reg;
                mem_wd = e_commit;
            end
            S_INSERT:
            begin
                mem_we = match_found_reg || free_found_reg;
                mem_wa = match_found_reg ? match_idx_reg : free_idx_reg;
                mem_wd = e_ins;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            valid_reg         <= '0;
            ring_cursor_reg   <= '0;
            cold_cursor_reg   <= '0;
            last_overdue_reg  <= 1'b0;
            last_first_reg    <= '0;
            burst_cfg_reg     <= 8'd4;
            due_cfg_reg       <= 16'd16;
            overdue_cfg_reg   <= 16'd64;
            cnt_reg           <= '0;
            rd_v_reg          <= 1'b0;
            rd_idx_reg        <= '0;
            cmd_reg           <= CMD_INSERT;
            addr_reg          <= '0;
            tag_reg           <= '0;
            rank_reg          <= '0;
            refresh_reg       <= 1'b0;
            bytes_reg         <= '0;
            length_reg        <= '0;
            preamble_reg      <= '0;
            repeats_reg       <= '0;
            match_found_reg   <= 1'b0;
            match_idx_reg     <= '0;
            match_age_reg     <= '0;
            match_refresh_reg <= 1'b0;
            free_found_reg    <= 1'b0;
            free_idx_reg      <= '0;
            sel_one_shot_reg  <= 1'b0;
            sel_idx_reg       <= '0;
            res_accepted_reg  <= 1'b0;
            res_source_reg    <= SRC_NONE;
            res_slot_reg      <= '0;
            res_bytes_reg     <= '0;
            res_length_reg    <= '0;
            res_preamble_reg  <= '0;
            out_valid_reg     <= 1'b0;
            out_accepted_reg  <= 1'b0;
            out_source_reg    <= SRC_NONE;
            out_slot_reg      <= '0;
            out_bytes_reg     <= '0;
            out_length_reg    <= '0;
            out_preamble_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PROMPT_BURST: burst_cfg_reg   <= cfg_data[7:0];
                    CFG_COLD_DUE:     due_cfg_reg     <= cfg_data;
                    CFG_COLD_OVERDUE: overdue_cfg_reg <= cfg_data;
                    default:          burst_cfg_reg   <= burst_cfg_reg;
                endcase
            end

            // In the emit state the output register is reloaded below instead.
            if (out_valid_reg && !out_stall && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end

            rd_v_reg   <= (state_reg == S_SCAN) && (cnt_reg < CNT_W'(SLOTS));
            rd_idx_reg <= cnt_reg[IDX_W-1:0];

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        cmd_reg         <= cmd_t'(cmd);
                        addr_reg        <= loco_address;
                        tag_reg         <= sub_key;
                        rank_reg        <= urgency;
                        refresh_reg     <= keep_refreshing;
                        bytes_reg       <= packet_bytes;
                        length_reg      <= packet_length;
                        preamble_reg    <= preamble_length;
                        repeats_reg     <= repeats;
                        match_found_reg <= 1'b0;
                        free_found_reg  <= 1'b0;
                        cnt_reg         <= '0;
                        res_accepted_reg <= 1'b1;
                        res_source_reg   <= SRC_NONE;
                        res_slot_reg     <= '0;
                        res_bytes_reg    <= '0;
                        res_length_reg   <= '0;
                        res_preamble_reg <= '0;
                        if (cmd_t'(cmd) == CMD_CLEAR)
                        begin
                            valid_reg        <= '0;
                            ring_cursor_reg  <= '0;
                            cold_cursor_reg  <= '0;
                            last_overdue_reg <= 1'b0;
                            state_reg        <= S_EMIT;
                        end
                        else if (cmd_t'(cmd) == CMD_INSERT && !keep_refreshing
                                 && repeats == '0)
                        begin
                            res_accepted_reg <= 1'b0;
                            state_reg        <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (cnt_reg < CNT_W'(SLOTS))
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (proc)
                    begin
                        if (cmd_reg == CMD_INSERT)
                        begin
                            if (slot_live && rd_data_reg.key == {addr_reg, tag_reg}
                                && !match_found_reg)
                            begin
                                match_found_reg   <= 1'b1;
                                match_idx_reg     <= rd_idx_reg;
                                match_age_reg     <= rd_data_reg.age;
                                match_refresh_reg <= rd_data_reg.refresh;
                            end
                            if (!slot_live && !free_found_reg)
                            begin
                                free_found_reg <= 1'b1;
                                free_idx_reg   <= rd_idx_reg;
                            end
                        end
                        else if (cmd_reg == CMD_REMOVE)
                        begin
                            if (slot_live && rd_data_reg.key[KEY_W-1:TAG_W] == addr_reg)
                            begin
                                valid_reg[rd_idx_reg] <= 1'b0;
                            end
                        end
                    end
                    if (scan_done)
                    begin
                        if (cmd_reg == CMD_INSERT)
                        begin
                            state_reg <= S_INSERT;
                        end
                        else if (cmd_reg == CMD_CYCLE)
                        begin
                            state_reg <= S_PICK;
                        end
                        else
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_PICK:
                begin
                    // Cursors move on the choice even when a spacer replaces the send.
                    ring_cursor_reg  <= ring_next;
                    cold_cursor_reg  <= cold_next;
                    last_overdue_reg <= last_overdue_next;
                    sel_one_shot_reg <= pick_one_shot;
                    sel_idx_reg      <= pick_idx;
                    if (pick_valid)
                    begin
                        state_reg <= S_COMMIT;
                    end
                    else
                    begin
                        last_first_reg <= '0;
                        res_source_reg <= SRC_IDLE;
                        state_reg      <= S_EMIT;
                    end
                end
                S_COMMIT:
                begin
                    if (spacer)
                    begin
                        last_first_reg <= '0;
                        res_source_reg <= SRC_SPACER;
                    end
                    else
                    begin
                        last_first_reg   <= head_byte;
                        res_source_reg   <= sel_one_shot_reg ? SRC_ONE_SHOT : SRC_REFRESH;
                        res_slot_reg     <= 4'(sel_idx_reg);
                        res_bytes_reg    <= emit_bytes;
                        res_length_reg   <= rd_data_reg.length;
                        res_preamble_reg <= rd_data_reg.preamble;
                        if (sel_one_shot_reg && e_commit.repeats == '0)
                        begin
                            valid_reg[sel_idx_reg] <= 1'b0;
                        end
                    end
                    state_reg <= S_EMIT;
                end
                S_INSERT:
                begin
                    if (match_found_reg)
                    begin
                        if (refresh_reg && match_refresh_reg && due_cfg_reg == '0)
                        begin
                            ring_cursor_reg <= match_idx_reg;
                        end
                        valid_reg[match_idx_reg] <= 1'b1;
                    end
                    else if (free_found_reg)
                    begin
                        valid_reg[free_idx_reg] <= 1'b1;
                    end
                    else
                    begin
                        res_accepted_reg <= 1'b0;
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_accepted_reg <= res_accepted_reg;
                        out_source_reg   <= res_source_reg;
                        out_slot_reg     <= res_slot_reg;
                        out_bytes_reg    <= res_bytes_reg;
                        out_length_reg   <= res_length_reg;
                        out_preamble_reg <= res_preamble_reg;
                        state_reg        <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = out_accepted_reg;
    assign source       = out_source_reg;
    assign chosen_slot  = out_slot_reg;
    assign out_bytes    = out_bytes_reg;
    assign out_length   = out_length_reg;
    assign out_preamble = out_preamble_reg;

endmodule
`default_nettype wire

// ===== src/dpss_pick.sv =====
// Candidate collector for the slot scan: one slot per cycle, cursor-relative first hits.
// Depends on dpss_pkg.
`default_nettype none
module dpss_pick
    import dpss_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       step,
    input  wire logic [$clog2(SLOTS)-1:0]   step_idx,
    input  wire tier_flags_t                flags,
    input  wire logic [2:0]                 rank,
    input  wire logic [$clog2(SLOTS)-1:0]   ring_cursor,
    input  wire logic [$clog2(SLOTS)-1:0]   cold_cursor,
    output      pick_found_t                found,
    output      logic [$clog2(SLOTS)-1:0]   one_shot_idx,
    output      logic [$clog2(SLOTS)-1:0]   any_idx,
    output      logic [$clog2(SLOTS)-1:0]   overdue_idx,
    output      logic [$clog2(SLOTS)-1:0]   burst_idx,
    output      logic [$clog2(SLOTS)-1:0]   due_idx
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int TIERS = 4;

    // Tier order: any, overdue, burst, due.
    logic [TIERS-1:0] tier_hit;
    logic [IDX_W-1:0] tier_cursor [TIERS];

    logic [TIERS-1:0] ge_found_reg;
    logic [TIERS-1:0] lo_found_reg;
    logic [IDX_W-1:0] ge_idx_reg [TIERS];
    logic [IDX_W-1:0] lo_idx_reg [TIERS];
    logic             os_found_reg;
    logic [IDX_W-1:0] os_idx_reg;
    logic [2:0]       os_rank_reg;
    logic             os_take;

    assign tier_hit       = {flags.due, flags.burst, flags.overdue, flags.any};
    assign tier_cursor[0] = ring_cursor;
    assign tier_cursor[1] = cold_cursor;
    assign tier_cursor[2] = ring_cursor;
    assign tier_cursor[3] = cold_cursor;
    assign os_take        = flags.one_shot && (!os_found_reg || rank < os_rank_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ge_found_reg <= '0;
            lo_found_reg <= '0;
            os_found_reg <= 1'b0;
        end
        else if (start)
        begin
            ge_found_reg <= '0;
            lo_found_reg <= '0;
            os_found_reg <= 1'b0;
        end
        else if (step)
        begin
            for (int t = 0; t < TIERS; t++)
            begin
                if (tier_hit[t] && step_idx >= tier_cursor[t])
                begin
                    ge_found_reg[t] <= 1'b1;
                end
                if (tier_hit[t])
                begin
                    lo_found_reg[t] <= 1'b1;
                end
            end
            if (os_take)
            begin
                os_found_reg <= 1'b1;
            end
        end
    end

    // Ascending slots: each tier keeps its first hit, the one-shot the lowest rank.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int t = 0; t < TIERS; t++)
            begin
                if (tier_hit[t] && step_idx >= tier_cursor[t] && !ge_found_reg[t])
                begin
                    ge_idx_reg[t] <= step_idx;
                end
                if (tier_hit[t] && !lo_found_reg[t])
                begin
                    lo_idx_reg[t] <= step_idx;
                end
            end
            if (os_take)
            begin
                os_idx_reg  <= step_idx;
                os_rank_reg <= rank;
            end
        end
    end

    assign found.one_shot = os_found_reg;
    assign found.any      = ge_found_reg[0] | lo_found_reg[0];
    assign found.overdue  = ge_found_reg[1] | lo_found_reg[1];
    assign found.burst    = ge_found_reg[2] | lo_found_reg[2];
    assign found.due      = ge_found_reg[3] | lo_found_reg[3];

    assign one_shot_idx = os_idx_reg;
    assign any_idx      = ge_found_reg[0] ? ge_idx_reg[0] : lo_idx_reg[0];
    assign overdue_idx  = ge_found_reg[1] ? ge_idx_reg[1] : lo_idx_reg[1];
    assign burst_idx    = ge_found_reg[2] ? ge_idx_reg[2] : lo_idx_reg[2];
    assign due_idx      = ge_found_reg[3] ? ge_idx_reg[3] : lo_idx_reg[3];

endmodule
`default_nettype wire

// ===== src/dpss_checker.sv =====
// Port-level checks for the packet slot scheduler, bound to the top level.
// Depends on dpss_pkg and dcc_packet_slot_scheduler_top.
`default_nettype none
module dpss_checker
    import dpss_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        accepted,
    input wire logic [2:0]  source,
    input wire logic [3:0]  chosen_slot,
    input wire logic [47:0] out_bytes,
    input wire logic [2:0]  out_length
);

    // Only one command is in work at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a command is in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(source) && $stable(accepted))
        else $error("stalled result changed");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (source == SRC_IDLE || source == SRC_SPACER)
        |-> chosen_slot == '0 && out_bytes == '0 && out_length == '0)
        else $error("idle result carries packet data");

    a_refused_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> source == SRC_NONE)
        else $error("refused insert reports a send");

endmodule

bind dcc_packet_slot_scheduler_top dpss_checker u_dpss_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .accepted    (accepted),
    .source      (source),
    .chosen_slot (chosen_slot),
    .out_bytes   (out_bytes),
    .out_length  (out_length)
);
`default_nettype wire

// ===== verif/tb_dcc_packet_slot_scheduler_top.sv =====
// Self-checking testbench for the packet slot scheduler top level.
// Predicts every result with a cycle-free model of the slot table and checks it per field.
// Depends on dpss_pkg and the scheduler RTL.
`default_nettype none
module tb_dcc_packet_slot_scheduler_top;
    import dpss_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 16;
    localparam int MAXB = 6;

    typedef struct {
        cmd_t        op;
        logic [13:0] addr;
        logic [3:0]  tag;
        logic [2:0]  rank;
        logic        refresh;
        logic [47:0] bytes;
        logic [2:0]  len;
        logic [7:0]  pre;
        logic [7:0]  reps;
    } command_t;

    typedef struct {
        logic        ok;
        source_t     src;
        logic [3:0]  slot;
        logic [47:0] bytes;
        logic [2:0]  len;
        logic [7:0]  pre;
    } sched_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] cmd = '0;
    logic [13:0] loco_address = '0;
    logic [3:0] sub_key = '0;
    logic [2:0] urgency = '0;
    logic keep_refreshing = 1'b0;
    logic [47:0] packet_bytes = '0;
    logic [2:0] packet_length = '0;
    logic [7:0] preamble_length = '0;
    logic [7:0] repeats = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic accepted;
    logic [2:0] source;
    logic [3:0] chosen_slot;
    logic [47:0] out_bytes;
    logic [2:0] out_length;
    logic [7:0] out_preamble;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    dcc_packet_slot_scheduler_top DUT (.*);

    always #6 clk = ~clk;

    // Predicted state of the slot table.
    logic [7:0]  burst_sends;
    logic [15:0] due_cycles;
    logic [15:0] overdue_cycles;
    logic        s_valid [NSLOT];
    logic        s_refresh [NSLOT];
    logic [17:0] s_key [NSLOT];
    logic [2:0]  s_rank [NSLOT];
    logic [47:0] s_bytes [NSLOT];
    logic [2:0]  s_len [NSLOT];
    logic [7:0]  s_pre [NSLOT];
    logic [7:0]  s_reps [NSLOT];
    logic [7:0]  s_burst [NSLOT];
    logic [15:0] s_age [NSLOT];
    logic [3:0]  ring_pos;
    logic [3:0]  cold_pos;
    logic        after_overdue;
    logic [7:0]  prev_first;

    command_t      pending_cmds[$];
    sched_result_t expected_results[$];
    int  errors = 0;
    logic quiet = 1'b0;
    int  idle_in = 0;
    int  idle_out = 0;
    int  stuck_cycles = 0;

    // Tier codes for the refresh scan.
    localparam int TIER_ANY = 0;
    localparam int TIER_OVERDUE = 1;
    localparam int TIER_BURST = 2;
    localparam int TIER_DUE = 3;

    function automatic logic tier_member(int i, int tier);
        if (!s_valid[i] || !s_refresh[i])
            return 1'b0;
        case (tier)
            TIER_OVERDUE: return s_age[i] >= overdue_cycles;
            TIER_BURST:   return s_burst[i] != 0;
            TIER_DUE:     return s_burst[i] == 0 && s_age[i] >= due_cycles;
            default:      return 1'b1;
        endcase
    endfunction

    function automatic int scan_tier(int tier);
        int i;
        for (int n = 0; n < NSLOT; n++)
        begin
            i = ((tier == TIER_OVERDUE || tier == TIER_DUE) ? cold_pos : ring_pos) + n;
            i = i % NSLOT;
            if (tier_member(i, tier))
            begin
                if (tier == TIER_OVERDUE || tier == TIER_DUE)
                    cold_pos = 4'((i + 1) % NSLOT);
                else
                    ring_pos = 4'((i + 1) % NSLOT);
                return i;
            end
        end
        return -1;
    endfunction

    function automatic int choose_refresh();
        int s;
        if (due_cycles == 0)
            return scan_tier(TIER_ANY);
        if (after_overdue)
        begin
            s = scan_tier(TIER_BURST);
            if (s >= 0)
            begin
                after_overdue = 1'b0;
                return s;
            end
        end
        s = scan_tier(TIER_OVERDUE);
        after_overdue = (s >= 0);
        if (s < 0)
            s = scan_tier(TIER_BURST);
        if (s < 0)
            s = scan_tier(TIER_DUE);
        return s;
    endfunction

    function automatic logic store_packet(command_t c);
        logic [17:0] key;
        int s;
        int keep;
        key = {c.addr, c.tag};
        s = -1;
        if (!c.refresh && c.reps == 0)
            return 1'b0;
        for (int i = 0; i < NSLOT && s < 0; i++)
            if (s_valid[i] && s_key[i] == key)
                s = i;
        if (s < 0)
        begin
            for (int i = 0; i < NSLOT && s < 0; i++)
                if (!s_valid[i])
                    s = i;
            if (s < 0)
                return 1'b0;
            s_age[s] = '0;
        end
        else if (c.refresh && s_refresh[s] && due_cycles == 0)
            ring_pos = 4'(s);
        keep = (c.len < MAXB) ? c.len : MAXB;
        s_bytes[s] = (keep >= 6) ? c.bytes : (c.bytes & ((48'd1 << (keep * 8)) - 48'd1));
        s_len[s] = c.len;
        s_pre[s] = c.pre;
        s_reps[s] = c.reps;
        s_key[s] = key;
        s_rank[s] = c.rank;
        s_refresh[s] = c.refresh;
        s_valid[s] = 1'b1;
        s_burst[s] = burst_sends;
        return 1'b1;
    endfunction

    function automatic sched_result_t run_packet_cycle();
        sched_result_t r;
        int s;
        logic single;
        logic [7:0] first;
        r = '{ok: 1'b1, src: SRC_IDLE, slot: '0, bytes: '0, len: '0, pre: '0};
        if (due_cycles != 0)
            for (int i = 0; i < NSLOT; i++)
                if (s_valid[i] && s_refresh[i] && s_age[i] != AGE_MAX)
                    s_age[i]++;
        s = -1;
        for (int i = 0; i < NSLOT; i++)
            if (s_valid[i] && !s_refresh[i] && s_reps[i] != 0)
                if (s < 0 || s_rank[i] < s_rank[s])
                    s = i;
        single = (s >= 0);
        if (!single)
            s = choose_refresh();
        if (s < 0)
        begin
            prev_first = '0;
            return r;
        end
        first = s_bytes[s][7:0];
        if (first >= SPACER_LO && first <= SPACER_HI && first == prev_first)
        begin
            prev_first = '0;
            r.src = SRC_SPACER;
            return r;
        end
        prev_first = first;
        r.slot = 4'(s);
        r.bytes = s_bytes[s];
        r.len = s_len[s];
        r.pre = s_pre[s];
        if (single)
        begin
            r.src = SRC_ONE_SHOT;
            s_reps[s]--;
            if (s_reps[s] == 0)
                s_valid[s] = 1'b0;
            return r;
        end
        r.src = SRC_REFRESH;
        if (s_burst[s] != 0)
            s_burst[s]--;
        s_age[s] = '0;
        return r;
    endfunction

    function automatic sched_result_t schedule_command(command_t c);
        sched_result_t r;
        r = '{ok: 1'b1, src: SRC_NONE, slot: '0, bytes: '0, len: '0, pre: '0};
        case (c.op)
            CMD_INSERT: r.ok = store_packet(c);
            CMD_REMOVE:
                for (int i = 0; i < NSLOT; i++)
                    if (s_valid[i] && s_key[i][17:4] == c.addr)
                        s_valid[i] = 1'b0;
            CMD_CLEAR:
            begin
                for (int i = 0; i < NSLOT; i++)
                    s_valid[i] = 1'b0;
                ring_pos = '0;
                cold_pos = '0;
                after_overdue = 1'b0;
            end
            default: r = run_packet_cycle();
        endcase
        return r;
    endfunction

    // Driver: presents queued commands and holds them while stalled.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_stall)
                ;
            else if (idle_in > 0)
            begin
                idle_in <= idle_in - 1;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0 && !(in_valid == 1'b0 && !quiet
                                                  && $urandom_range(0, 9) == 0))
            begin
                command_t c;
                c = pending_cmds.pop_front();
                expected_results.push_back(schedule_command(c));
                in_valid <= 1'b1;
                cmd <= c.op;
                loco_address <= c.addr;
                sub_key <= c.tag;
                urgency <= c.rank;
                keep_refreshing <= c.refresh;
                packet_bytes <= c.bytes;
                packet_length <= c.len;
                preamble_length <= c.pre;
                repeats <= c.reps;
                if (!quiet && $urandom_range(0, 7) == 0)
                    idle_in <= $urandom_range(1, 5);
            end
            else
            begin
                in_valid <= 1'b0;
                if (!quiet && pending_cmds.size() > 0 && $urandom_range(0, 3) == 0)
                    idle_in <= $urandom_range(1, 5);
            end
        end
    end

    // Monitor: checks each transfer out and drives random stall bursts.
    always @(posedge clk)
    begin
        sched_result_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no command pending");
                    errors++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (accepted !== e.ok)
                    begin
                        $error("accepted: expected %0d got %0d", e.ok, accepted);
                        errors++;
                    end
                    if (source !== e.src)
                    begin
                        $error("source: expected %0d got %0d", e.src, source);
                        errors++;
                    end
                    if (chosen_slot !== e.slot)
                    begin
                        $error("chosen_slot: expected %0d got %0d", e.slot, chosen_slot);
                        errors++;
                    end
                    if (out_bytes !== e.bytes)
                    begin
                        $error("out_bytes: expected %h got %h", e.bytes, out_bytes);
                        errors++;
                    end
                    if (out_length !== e.len)
                    begin
                        $error("out_length: expected %0d got %0d", e.len, out_length);
                        errors++;
                    end
                    if (out_preamble !== e.pre)
                    begin
                        $error("out_preamble: expected %0d got %0d", e.pre, out_preamble);
                        errors++;
                    end
                end
            end
            if (idle_out > 0)
            begin
                idle_out <= idle_out - 1;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                idle_out <= $urandom_range(0, 4);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles <= 0;
            else
            begin
                stuck_cycles <= stuck_cycles + 1;
                if (stuck_cycles > 2000)
                begin
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    // A small address pool keeps merges, removes and full-table refusals frequent.
    function automatic command_t random_command(int mix);
        command_t c;
        int r;
        r = $urandom_range(0, 99);
        c.addr = ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom_range(0, 5));
        c.tag = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
        c.rank = 3'($urandom);
        c.refresh = 1'($urandom);
        c.bytes = {16'($urandom), 32'($urandom)};
        if ($urandom_range(0, 2) == 0)
            c.bytes[7:0] = 8'($urandom_range(8'h70, 8'h7F));
        c.len = 3'($urandom_range(0, 7));
        c.pre = 8'($urandom);
        c.reps = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
        if ($urandom_range(0, 30) == 0)
            c.reps = 8'($urandom);
        if (r < mix)
            c.op = CMD_INSERT;
        else if (r < mix + 6)
            c.op = CMD_REMOVE;
        else if (r < mix + 8)
            c.op = CMD_CLEAR;
        else
            c.op = CMD_CYCLE;
        return c;
    endfunction

    task automatic write_register(cfg_index_t idx, logic [15:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PROMPT_BURST: burst_sends = value[7:0];
            CFG_COLD_DUE:     due_cycles = value;
            default:          overdue_cycles = value;
        endcase
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || expected_results.size() > 0 || in_valid)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic command_t make_cmd(cmd_t op, int addr, int tag, int rank, logic rf,
                                          logic [47:0] b, int len, int reps);
        command_t c;
        c = '{op: op, addr: 14'(addr), tag: 4'(tag), rank: 3'(rank), refresh: rf,
              bytes: b, len: 3'(len), pre: 8'(addr + 20), reps: 8'(reps)};
        return c;
    endfunction

    initial
    begin
        burst_sends = 8'd4;
        due_cycles = 16'd16;
        overdue_cycles = 16'd64;
        for (int i = 0; i < NSLOT; i++)
        begin
            s_valid[i] = 1'b0;
            s_burst[i] = '0;
            s_age[i] = '0;
        end
        ring_pos = '0;
        cold_pos = '0;
        after_overdue = 1'b0;
        prev_first = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, refusals, spacer, merge, remove, clear, full table.
        pending_cmds.push_back(make_cmd(CMD_CYCLE, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 1, 0, 3, 0, 48'h55, 1, 0));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 16383, 15, 7, 0, 48'hFFFFFFFFFFFF, 7, 255));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 2, 1, 0, 0, 48'h0171, 2, 2));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 3, 0, 0, 1, 48'h0171, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 4, 0, 0, 1, 48'h12345678AB7F, 6, 0));
        for (int k = 0; k < 5; k++)
            pending_cmds.push_back(make_cmd(CMD_CYCLE, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 4, 0, 1, 1, 48'h7F, 3, 0));
        pending_cmds.push_back(make_cmd(CMD_REMOVE, 16383, 0, 0, 0, 0, 0, 0));
        for (int k = 0; k < 14; k++)
            pending_cmds.push_back(make_cmd(CMD_INSERT, 100 + k, k, k, 1, 48'(k), 1, 1));
        pending_cmds.push_back(make_cmd(CMD_CYCLE, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        drain();

        // Random phases across register settings, extremes included.
        for (int ph = 0; ph < 11; ph++)
        begin
            case (ph)
                0: begin write_register(CFG_COLD_DUE, 16'd0);
                         write_register(CFG_PROMPT_BURST, 16'd0); end
                1: begin write_register(CFG_COLD_DUE, 16'd3);
                         write_register(CFG_COLD_OVERDUE, 16'd6);
                         write_register(CFG_PROMPT_BURST, 16'd2); end
                2: begin write_register(CFG_PROMPT_BURST, 16'd255);
                         write_register(CFG_COLD_OVERDUE, 16'd0); end
                3: begin write_register(CFG_COLD_DUE, 16'd65535);
                         write_register(CFG_COLD_OVERDUE, 16'd65535); end
                4: begin write_register(CFG_COLD_DUE, 16'd1);
                         write_register(CFG_COLD_OVERDUE, 16'd2);
                         write_register(CFG_PROMPT_BURST, 16'd1); end
                5: write_register(CFG_COLD_DUE, 16'd0);
                6: begin write_register(CFG_COLD_DUE, 16'd8);
                         write_register(CFG_COLD_OVERDUE, 16'd12); end
                default: begin
                    write_register(CFG_PROMPT_BURST, 16'($urandom_range(0, 6)));
                    write_register(CFG_COLD_DUE, 16'($urandom_range(0, 10)));
                    write_register(CFG_COLD_OVERDUE, 16'($urandom_range(0, 20)));
                end
            endcase
            if (ph == 10)
                quiet = 1'b1;
            for (int k = 0; k < 150; k++)
                pending_cmds.push_back(random_command((ph % 3 == 0) ? 45 : 30));
            drain();
        end
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
